// ----- hdl/bbt_pkg.sv -----
// Package for the bars/beats/ticks timebase: datapath operation codes,
// register indexes, saturation limits and the controller/datapath structs.
// No dependencies.
package bbt_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_BPB    = 3'd0;
  localparam logic [2:0] REG_BTYPE  = 3'd1;
  localparam logic [2:0] REG_TPB    = 3'd2;
  localparam logic [2:0] REG_TEMPO  = 3'd3;
  localparam logic [2:0] REG_FRATE  = 3'd4;
  localparam logic [2:0] REG_AV_EN  = 3'd5;
  localparam logic [2:0] REG_AV_Q16 = 3'd6;

  // Divider geometry
  localparam int unsigned DivNumW = 68;
  localparam int unsigned DivDenW = 35;
  localparam int unsigned DivCntW = 7;

  // Frames-per-minute scale: denominator is the frame rate times this
  localparam logic [15:0] FRAME_SCALE = 16'd60000;

  localparam logic [30:0] BAR_MAX = 31'h7FFF_FFFF;
  localparam logic [62:0] BST_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

  // Datapath operations
  localparam logic [4:0] OP_NONE      = 5'd0;
  localparam logic [4:0] OP_LOAD      = 5'd1;
  localparam logic [4:0] OP_RMUL_A    = 5'd2;
  localparam logic [4:0] OP_RMUL_LO   = 5'd3;
  localparam logic [4:0] OP_RMUL_HI   = 5'd4;
  localparam logic [4:0] OP_AMUL_P    = 5'd5;
  localparam logic [4:0] OP_AMUL_T    = 5'd6;
  localparam logic [4:0] OP_DIV_FRAME = 5'd7;
  localparam logic [4:0] OP_CAP_ABS   = 5'd8;
  localparam logic [4:0] OP_CAP_WHOLE = 5'd9;
  localparam logic [4:0] OP_DIV_TPB   = 5'd10;
  localparam logic [4:0] OP_CAP_BEAT  = 5'd11;
  localparam logic [4:0] OP_ATOT      = 5'd12;
  localparam logic [4:0] OP_DIV_BPB   = 5'd13;
  localparam logic [4:0] OP_RFIN      = 5'd14;
  localparam logic [4:0] OP_AINC      = 5'd15;
  localparam logic [4:0] OP_AFIN      = 5'd16;
  localparam logic [4:0] OP_EMIT      = 5'd17;

  typedef struct packed {
    logic [4:0] op;
  } bbt_cmd_t;

  typedef struct packed {
    logic need_repos;  // reposition flag or pending recompute (reset or time setting write)
    logic div_done;    // divider finished this cycle
    logic out_free;    // output register can take a result
  } bbt_stat_t;

endpackage

// ----- hdl/bbt_div.sv -----
// Restoring divider, one quotient bit per cycle, 68-bit dividend.
// Depends on bbt_pkg.
module bbt_div
  import bbt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] dividend_i,
  input  logic [DivDenW-1:0] divisor_i,
  output logic               done_o,
  output logic [DivNumW-1:0] quot_o,
  output logic [DivDenW-1:0] rem_o
);

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivNumW-1:0] quo_q, quo_d;
  logic [DivDenW-1:0] rem_q, rem_d, den_q;
  logic [DivDenW:0]   trial;
  logic               ge;

  // One restoring step
  always_comb begin
    trial = {rem_q, quo_q[DivNumW-1]};
    ge    = (trial >= {1'b0, den_q});
    rem_d = ge ? DivDenW'(trial - {1'b0, den_q}) : trial[DivDenW-1:0];
    quo_d = {quo_q[DivNumW-2:0], ge};
  end

  // Control: load on start, count down the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DivNumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Payload: operands and partial results
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// ----- hdl/bbt_ctrl.sv -----
// Sequencer for the timebase: walks the reposition or advance step list
// and issues at most one datapath operation per state. Depends on bbt_pkg.
module bbt_ctrl
  import bbt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  bbt_stat_t stat_i,
  output bbt_cmd_t  cmd_o
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_SEL  = 5'd1;
  localparam logic [4:0] S_RMA  = 5'd2;
  localparam logic [4:0] S_RLO  = 5'd3;
  localparam logic [4:0] S_RHI  = 5'd4;
  localparam logic [4:0] S_AMP  = 5'd5;
  localparam logic [4:0] S_AMT  = 5'd6;
  localparam logic [4:0] S_DF   = 5'd7;
  localparam logic [4:0] S_DFW  = 5'd8;
  localparam logic [4:0] S_CF   = 5'd9;
  localparam logic [4:0] S_DT   = 5'd10;
  localparam logic [4:0] S_DTW  = 5'd11;
  localparam logic [4:0] S_CB   = 5'd12;
  localparam logic [4:0] S_AT   = 5'd13;
  localparam logic [4:0] S_DB   = 5'd14;
  localparam logic [4:0] S_DBW  = 5'd15;
  localparam logic [4:0] S_RF   = 5'd16;
  localparam logic [4:0] S_AI   = 5'd17;
  localparam logic [4:0] S_AF   = 5'd18;
  localparam logic [4:0] S_EM   = 5'd19;

  logic [4:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and operation
  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_SEL;
        end
      end
      S_SEL:  state_d = stat_i.need_repos ? S_RMA : S_AMP;
      S_RMA: begin cmd_o.op = OP_RMUL_A;  state_d = S_RLO; end
      S_RLO: begin cmd_o.op = OP_RMUL_LO; state_d = S_RHI; end
      S_RHI: begin cmd_o.op = OP_RMUL_HI; state_d = S_DF;  end
      S_AMP: begin cmd_o.op = OP_AMUL_P;  state_d = S_AMT; end
      S_AMT: begin cmd_o.op = OP_AMUL_T;  state_d = S_DF;  end
      S_DF:  begin cmd_o.op = OP_DIV_FRAME; state_d = S_DFW; end
      S_DFW: begin
        if (stat_i.div_done) state_d = S_CF;
      end
      S_CF: begin
        cmd_o.op = stat_i.need_repos ? OP_CAP_ABS : OP_CAP_WHOLE;
        state_d  = S_DT;
      end
      S_DT:  begin cmd_o.op = OP_DIV_TPB; state_d = S_DTW; end
      S_DTW: begin
        if (stat_i.div_done) state_d = S_CB;
      end
      S_CB: begin
        cmd_o.op = OP_CAP_BEAT;
        state_d  = stat_i.need_repos ? S_DB : S_AT;
      end
      S_AT:  begin cmd_o.op = OP_ATOT;    state_d = S_DB;  end
      S_DB:  begin cmd_o.op = OP_DIV_BPB; state_d = S_DBW; end
      S_DBW: begin
        if (stat_i.div_done) state_d = stat_i.need_repos ? S_RF : S_AI;
      end
      S_RF:  begin cmd_o.op = OP_RFIN; state_d = S_EM; end
      S_AI:  begin cmd_o.op = OP_AINC; state_d = S_AF; end
      S_AF:  begin cmd_o.op = OP_AFIN; state_d = S_EM; end
      S_EM: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/bbt_dpath.sv -----
// Datapath for the timebase: settings, position state, multipliers, the
// shared divider and the output register. Depends on bbt_pkg and bbt_div.
module bbt_dpath
  import bbt_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         in_repos_i,
  input  logic [31:0]  in_frame_i,
  input  logic [15:0]  in_period_i,
  input  bbt_cmd_t     cmd_i,
  output bbt_stat_t    stat_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [30:0]  bar_o,
  output logic [5:0]   beat_o,
  output logic [15:0]  tick_o,
  output logic [62:0]  bst_o,
  output logic [5:0]   bpb_o,
  output logic [5:0]   btype_o,
  output logic [15:0]  tpb_o,
  output logic [19:0]  tempo_o,
  output logic         av_valid_o,
  output logic [31:0]  av_ratio_o
);

  // Settings
  logic [5:0]  bpb_q, btype_q;
  logic [15:0] tpb_q;
  logic [19:0] tempo_q;
  logic [18:0] frate_q;
  logic        av_en_q;
  logic [31:0] av_q16_q;

  // Position state
  logic [15:0] tw_q;
  logic [34:0] rem_q;
  logic [30:0] bar_q;
  logic [5:0]  beat_q;
  logic [62:0] bst_q;
  logic        pend_q;

  // Working registers
  logic        repos_q;
  logic [31:0] frame_q;
  logic [15:0] period_q;
  logic [34:0] d_q;
  logic [51:0] a_q;
  logic [67:0] num_q;
  logic [63:0] abs_q;
  logic [63:0] q1_q;
  logic        ovalid_q;

  // Output register
  logic [30:0] o_bar_q;
  logic [5:0]  o_beat_q, o_bpb_q, o_btype_q;
  logic [15:0] o_tick_q, o_tpb_q;
  logic [62:0] o_bst_q;
  logic [19:0] o_tempo_q;
  logic        o_av_valid_q;
  logic [31:0] o_av_q;

  logic [15:0] tpb1;
  logic [5:0]  bpb1;
  logic [18:0] frate1;

  logic               div_start, div_done;
  logic [DivNumW-1:0] div_num, div_quot;
  logic [DivDenW-1:0] div_den, div_rem;
  logic [5:0]         r6;

  logic [51:0]        mul_a, mul_t;
  logic [41:0]        mul_lo, mul_hi;
  logic [31:0]        mul_p;
  logic [34:0]        mul_d;
  logic [21:0]        r_tpb;
  logic signed [7:0]  beat_diff;
  logic signed [24:0] diff_tpb;
  logic [63:0]        inc;
  logic [62:0]        bst_rep;
  logic [40:0]        bar_sum;
  logic [63:0]        bst_sum;
  logic [16:0]        tick_rnd;
  logic               rnd_up;

  // Zero tick, beat and frame rate settings count as one in the arithmetic
  assign tpb1   = (tpb_q == '0) ? 16'd1 : tpb_q;
  assign bpb1   = (bpb_q == '0) ? 6'd1 : bpb_q;
  assign frate1 = (frate_q == '0) ? 19'd1 : frate_q;

  assign r6 = div_rem[5:0];

  // Multipliers, one per operation step
  assign mul_d     = {16'b0, frate1} * {19'b0, FRAME_SCALE};
  assign mul_a     = {20'b0, frame_q} * {32'b0, tempo_q};
  assign mul_lo    = {16'b0, a_q[25:0]} * {26'b0, tpb1};
  assign mul_hi    = {16'b0, a_q[51:26]} * {26'b0, tpb1};
  assign mul_p     = {16'b0, period_q} * {16'b0, tpb1};
  assign mul_t     = {20'b0, a_q[31:0]} * {32'b0, tempo_q};
  assign r_tpb     = {16'b0, r6} * {6'b0, tpb1};
  assign beat_diff = $signed({2'b0, beat_q}) - 8'sd1 - $signed({2'b0, r6});
  assign diff_tpb  = 25'(beat_diff * $signed({1'b0, tpb1}));
  assign inc       = (abs_q - {48'b0, tw_q}) + {{39{diff_tpb[24]}}, diff_tpb};
  assign bst_rep   = 63'(abs_q - {48'b0, tw_q} - {42'b0, r_tpb});
  assign bar_sum   = {10'b0, bar_q} + div_quot[40:0];
  assign bst_sum   = {1'b0, bst_q} + num_q[63:0];

  // Round the tick half up
  assign rnd_up   = ({rem_q, 1'b0} >= {1'b0, d_q});
  assign tick_rnd = {1'b0, tw_q} + {16'b0, rnd_up};

  // Divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_num   = num_q;
    div_den   = d_q;
    case (cmd_i.op)
      OP_DIV_FRAME: begin
        div_start = 1'b1;
      end
      OP_DIV_TPB: begin
        div_start = 1'b1;
        div_num   = {4'b0, abs_q};
        div_den   = {19'b0, tpb1};
      end
      OP_DIV_BPB: begin
        div_start = 1'b1;
        div_num   = {4'b0, q1_q};
        div_den   = {29'b0, bpb1};
      end
      default: ;
    endcase
  end

  bbt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Settings and position state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpb_q    <= 6'd4;
      btype_q  <= 6'd4;
      tpb_q    <= 16'd1920;
      tempo_q  <= 20'd120000;
      frate_q  <= 19'd48000;
      av_en_q  <= 1'b0;
      av_q16_q <= '0;
      tw_q     <= '0;
      rem_q    <= '0;
      bar_q    <= 31'd1;
      beat_q   <= 6'd1;
      bst_q    <= '0;
      pend_q   <= 1'b1;
      ovalid_q <= 1'b0;
    end else begin
      // Register writes; time settings force a recompute
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_BPB:    begin bpb_q   <= cfg_wdata_i[5:0];  pend_q <= 1'b1; end
          REG_BTYPE:  begin btype_q <= cfg_wdata_i[5:0];  pend_q <= 1'b1; end
          REG_TPB:    begin tpb_q   <= cfg_wdata_i[15:0]; pend_q <= 1'b1; end
          REG_TEMPO:  begin tempo_q <= cfg_wdata_i[19:0]; pend_q <= 1'b1; end
          REG_FRATE:  begin frate_q <= cfg_wdata_i[18:0]; pend_q <= 1'b1; end
          REG_AV_EN:  av_en_q  <= cfg_wdata_i[0];
          REG_AV_Q16: av_q16_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      case (cmd_i.op)
        OP_CAP_WHOLE: rem_q <= div_rem;
        OP_CAP_BEAT:  tw_q  <= div_rem[15:0];
        OP_RFIN: begin
          beat_q <= r6 + 6'd1;
          rem_q  <= '0;
          bst_q  <= bst_rep;
          bar_q  <= (div_quot >= {37'b0, BAR_MAX}) ? BAR_MAX :
                    31'(div_quot[30:0] + 31'd1);
          pend_q <= 1'b0;
        end
        OP_AFIN: begin
          beat_q <= r6 + 6'd1;
          bar_q  <= ((|div_quot[67:41]) || (bar_sum >= {10'b0, BAR_MAX})) ?
                    BAR_MAX : bar_sum[30:0];
          bst_q  <= (bst_sum >= {1'b0, BST_MAX}) ? BST_MAX : bst_sum[62:0];
        end
        default: ;
      endcase
      // Output handshake: set on emit, drop on transfer
      if (cmd_i.op == OP_EMIT) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        repos_q  <= in_repos_i;
        frame_q  <= in_frame_i;
        period_q <= in_period_i;
        d_q      <= mul_d;
      end
      OP_RMUL_A:    a_q   <= mul_a;
      OP_RMUL_LO:   num_q <= {26'b0, mul_lo};
      OP_RMUL_HI:   num_q <= num_q + {mul_hi, 26'b0};
      OP_AMUL_P:    a_q   <= {20'b0, mul_p};
      OP_AMUL_T:    num_q <= {16'b0, mul_t} + {33'b0, rem_q};
      OP_CAP_ABS:   abs_q <= div_quot[63:0];
      OP_CAP_WHOLE: abs_q <= div_quot[63:0] + {48'b0, tw_q};
      OP_CAP_BEAT:  q1_q  <= div_quot[63:0];
      OP_ATOT:      q1_q  <= q1_q + {58'b0, beat_q} - 64'd1;
      OP_AINC:      num_q <= {4'b0, inc};
      OP_EMIT: begin
        o_bar_q      <= bar_q;
        o_beat_q     <= beat_q;
        o_tick_q     <= tick_rnd[15:0];
        o_bst_q      <= bst_q;
        o_bpb_q      <= bpb_q;
        o_btype_q    <= btype_q;
        o_tpb_q      <= tpb_q;
        o_tempo_q    <= tempo_q;
        o_av_valid_q <= av_en_q;
        o_av_q       <= av_en_q ? av_q16_q : 32'd0;
      end
      default: ;
    endcase
  end

  assign stat_o.need_repos = repos_q || pend_q;
  assign stat_o.div_done   = div_done;
  assign stat_o.out_free   = !ovalid_q || out_ready_i;

  assign out_valid_o = ovalid_q;
  assign bar_o       = o_bar_q;
  assign beat_o      = o_beat_q;
  assign tick_o      = o_tick_q;
  assign bst_o       = o_bst_q;
  assign bpb_o       = o_bpb_q;
  assign btype_o     = o_btype_q;
  assign tpb_o       = o_tpb_q;
  assign tempo_o     = o_tempo_q;
  assign av_valid_o  = o_av_valid_q;
  assign av_ratio_o  = o_av_q;

endmodule

// ----- hdl/bars_beats_ticks_timebase.sv -----
// Top level of the bars/beats/ticks timebase: stream ports, controller
// and datapath. Depends on bbt_pkg, bbt_ctrl and bbt_dpath.
//
// Channel   Dir  Carries
// s_axis    in   one audio period: reposition flag, frame, period length
// m_axis    out  bar, beat, tick, bar start tick and setting echoes
// cfg       in   register writes, index 0..6, no read-back
//
// Each item runs three passes of the shared 68-step divider, plus a
// handful of multiply and update steps.
// Reset is asynchronous and active low; it loads default settings and
// marks the position for recompute on the first period.
// A finished result waits in the output register while the next period
// is accepted; the emit step holds only if that register is still full.
module bars_beats_ticks_timebase
  import bbt_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // frame_pos [31:0], period_frames [47:32]
  input  logic [47:0]  s_axis_tdata,
  // reposition [0]
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // bar_number [30:0], beat_number [36:31], tick_number [52:37],
  // bar_start_ticks [115:53], beats_per_bar_out [121:116],
  // beat_type_out [127:122], ticks_per_beat_out [143:128],
  // tempo_out [163:144], av_ratio_out [195:164], zero [199:196]
  output logic [199:0] m_axis_tdata,
  // av_ratio_valid [0]
  output logic [0:0]   m_axis_tuser
);

  bbt_cmd_t  cmd;
  bbt_stat_t stat;

  logic [30:0] bar;
  logic [5:0]  beat, bpb, btype;
  logic [15:0] tick, tpb;
  logic [62:0] bst;
  logic [19:0] tempo;
  logic        av_valid;
  logic [31:0] av_ratio;

  bbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bbt_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_repos_i  (s_axis_tuser[0]),
    .in_frame_i  (s_axis_tdata[31:0]),
    .in_period_i (s_axis_tdata[47:32]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .bar_o       (bar),
    .beat_o      (beat),
    .tick_o      (tick),
    .bst_o       (bst),
    .bpb_o       (bpb),
    .btype_o     (btype),
    .tpb_o       (tpb),
    .tempo_o     (tempo),
    .av_valid_o  (av_valid),
    .av_ratio_o  (av_ratio)
  );

  // Pack the result fields, lowest first
  assign m_axis_tdata = {4'b0, av_ratio, tempo, tpb, btype, bpb, bst, tick, beat, bar};
  assign m_axis_tuser = av_valid;

endmodule
